// File: rtl/core/xdec_pkg.sv
`timescale 1ns / 1ps

package xdec_pkg;

  localparam int WIN_BYTES   = 11;
  localparam int WIN_W       = 8 * WIN_BYTES;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;

  localparam logic [3:0] AVAIL_MAX = 4'(WIN_BYTES);
  localparam logic [3:0] REG_NONE  = 4'd8;
  localparam logic [2:0] SIB_NO_INDEX = 3'd4;
  localparam logic [2:0] RM_DISP32    = 3'd5;
  localparam logic [2:0] RM_SIB       = 3'd4;

  // Opcodes
  localparam logic [7:0] OP_ADD_RM_LO = 8'h00;
  localparam logic [7:0] OP_ADD_RM_HI = 8'h03;
  localparam logic [7:0] OP_SUB_RM_LO = 8'h28;
  localparam logic [7:0] OP_SUB_RM_HI = 8'h2B;
  localparam logic [7:0] OP_CMP_RM_LO = 8'h38;
  localparam logic [7:0] OP_CMP_RM_HI = 8'h3B;
  localparam logic [7:0] OP_MOV_RM_LO = 8'h88;
  localparam logic [7:0] OP_MOV_RM_HI = 8'h8B;
  localparam logic [7:0] OP_ADD_EAX   = 8'h05;
  localparam logic [7:0] OP_SUB_EAX   = 8'h2D;
  localparam logic [7:0] OP_CMP_EAX   = 8'h3D;
  localparam logic [7:0] OP_REG_LO    = 8'h40;
  localparam logic [7:0] OP_REG_HI    = 8'h5F;
  localparam logic [7:0] OP_JE        = 8'h74;
  localparam logic [7:0] OP_JNE       = 8'h75;
  localparam logic [7:0] OP_JMP8      = 8'hEB;
  localparam logic [7:0] OP_CALL      = 8'hE8;
  localparam logic [7:0] OP_JMP32     = 8'hE9;
  localparam logic [7:0] OP_GRP_IMM32 = 8'h81;
  localparam logic [7:0] OP_GRP_IMM8  = 8'h83;
  localparam logic [7:0] OP_MOV_IMM   = 8'hC7;
  localparam logic [7:0] OP_PUSHA     = 8'h60;
  localparam logic [7:0] OP_POPA      = 8'h61;
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_PUSHF     = 8'h9C;
  localparam logic [7:0] OP_POPF      = 8'h9D;
  localparam logic [7:0] OP_RET       = 8'hC3;

  // ALU selector in opcode bits 5:3
  localparam logic [2:0] ALU_SEL_ADD = 3'd0;
  localparam logic [2:0] ALU_SEL_SUB = 3'd5;

  // Register-form opcode group in bits 4:3
  localparam logic [1:0] REG_GRP_INC  = 2'd0;
  localparam logic [1:0] REG_GRP_DEC  = 2'd1;
  localparam logic [1:0] REG_GRP_PUSH = 2'd2;

  // Mod field
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  typedef enum logic [4:0] {
    KIND_INVALID, KIND_ADD, KIND_SUB, KIND_CMP, KIND_INC, KIND_DEC,
    KIND_PUSH, KIND_POP, KIND_PUSHA, KIND_POPA, KIND_JE, KIND_JNE,
    KIND_OR, KIND_ADC, KIND_SBB, KIND_AND, KIND_XOR, KIND_MOV,
    KIND_NOP, KIND_PUSHF, KIND_POPF, KIND_RET, KIND_CALL, KIND_JMP
  } ins_kind_t;

  typedef enum logic [1:0] {RM_NONE, RM_REG, RM_MEM, RM_IMM} rm_kind_t;
  typedef enum logic [1:0] {SEC_NONE, SEC_REG, SEC_IMM} sec_kind_t;
  typedef enum logic [1:0] {VSRC_NONE, VSRC_BYTE, VSRC_WORD} val_src_t;

  // Stage 1 result: decoded shape, value fields still located by byte position
  typedef struct packed {
    logic       known;
    ins_kind_t  kind;
    logic [3:0] len;
    logic [3:0] avail;
    logic       swapped;
    rm_kind_t   rk;
    logic [3:0] rbase;
    logic [3:0] ridx;
    logic [1:0] rscale;
    val_src_t   rv_src;
    logic [2:0] rv_pos;
    sec_kind_t  sk;
    val_src_t   sv_src;
    logic [2:0] sv_reg;
    logic [2:0] sv_pos;
  } s1_ctl_t;

  // Decoded result, laid out as the output word (last field in the lowest bits)
  typedef struct packed {
    logic [31:0] second_value;
    sec_kind_t   second_kind;
    logic [31:0] rm_value;
    logic [1:0]  rm_scale;
    logic [3:0]  rm_index;
    logic [3:0]  rm_base;
    rm_kind_t    rm_kind;
    logic        swapped;
    logic [3:0]  length;
    ins_kind_t   kind;
  } dec_res_t;

  function automatic ins_kind_t group_kind(input logic [2:0] sel);
    ins_kind_t k;
    case (sel)
      3'd0:    k = KIND_ADD;
      3'd1:    k = KIND_OR;
      3'd2:    k = KIND_ADC;
      3'd3:    k = KIND_SBB;
      3'd4:    k = KIND_AND;
      3'd5:    k = KIND_SUB;
      3'd6:    k = KIND_XOR;
      default: k = KIND_CMP;
    endcase
    return k;
  endfunction

  function automatic ins_kind_t alu_kind(input logic [2:0] sel);
    ins_kind_t k;
    case (sel)
      ALU_SEL_ADD: k = KIND_ADD;
      ALU_SEL_SUB: k = KIND_SUB;
      default:     k = KIND_CMP;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/xdec_cls.sv
`timescale 1ns / 1ps

// Stage 1: classify the opcode, parse ModRM/SIB, locate displacement and immediate.
module xdec_cls (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [xdec_pkg::IN_TDATA_W-1:0] in_data,
  output logic                          s1_v_r,
  output logic [xdec_pkg::WIN_W-1:0]    s1_win_r,
  output xdec_pkg::s1_ctl_t             s1_ctl_r
);

  logic [7:0] op;
  logic [7:0] sib;
  logic [1:0] mod_f;
  logic [2:0] r1;
  logic [2:0] r2;
  logic [3:0] avail_raw;
  logic [3:0] avail_c;
  logic       has_sib;
  logic [2:0] disp_pos;

  xdec_pkg::val_src_t m_src;
  logic [2:0]         m_end;
  xdec_pkg::rm_kind_t m_rk;
  logic [3:0]         m_base;
  logic [3:0]         m_idx;
  logic [1:0]         m_scale;

  xdec_pkg::s1_ctl_t ctl_nxt;

  assign op        = in_data[7:0];
  assign mod_f     = in_data[15:14];
  assign r2        = in_data[13:11];
  assign r1        = in_data[10:8];
  assign sib       = in_data[23:16];
  assign avail_raw = in_data[xdec_pkg::WIN_W+3:xdec_pkg::WIN_W];
  assign avail_c   = (avail_raw > xdec_pkg::AVAIL_MAX) ? xdec_pkg::AVAIL_MAX : avail_raw;
  assign has_sib   = (mod_f != xdec_pkg::MOD_REG) && (r1 == xdec_pkg::RM_SIB);
  assign disp_pos  = has_sib ? 3'd3 : 3'd2;

  // ModRM operand shape
  always_comb begin
    m_src   = xdec_pkg::VSRC_NONE;
    m_end   = disp_pos;
    m_rk    = xdec_pkg::RM_MEM;
    m_base  = {1'b0, r1};
    m_idx   = xdec_pkg::REG_NONE;
    m_scale = 2'd0;
    case (mod_f)
      xdec_pkg::MOD_NODISP: begin
        if (r1 == xdec_pkg::RM_DISP32) begin
          m_src  = xdec_pkg::VSRC_WORD;
          m_end  = disp_pos + 3'd4;
          m_base = xdec_pkg::REG_NONE;
        end
      end
      xdec_pkg::MOD_DISP8: begin
        m_src = xdec_pkg::VSRC_BYTE;
        m_end = disp_pos + 3'd1;
      end
      xdec_pkg::MOD_DISP32: begin
        m_src = xdec_pkg::VSRC_WORD;
        m_end = disp_pos + 3'd4;
      end
      default: m_rk = xdec_pkg::RM_REG;
    endcase
    if (has_sib) begin
      m_base  = {1'b0, sib[2:0]};
      m_idx   = (sib[5:3] == xdec_pkg::SIB_NO_INDEX) ? xdec_pkg::REG_NONE : {1'b0, sib[5:3]};
      m_scale = sib[7:6];
    end
  end

  always_comb begin
    ctl_nxt       = '0;
    ctl_nxt.avail = avail_c;
    ctl_nxt.len   = 4'd1;
    unique case (op) inside
      [xdec_pkg::OP_ADD_RM_LO:xdec_pkg::OP_ADD_RM_HI],
      [xdec_pkg::OP_SUB_RM_LO:xdec_pkg::OP_SUB_RM_HI],
      [xdec_pkg::OP_CMP_RM_LO:xdec_pkg::OP_CMP_RM_HI],
      [xdec_pkg::OP_MOV_RM_LO:xdec_pkg::OP_MOV_RM_HI]: begin
        ctl_nxt.known   = 1'b1;
        ctl_nxt.kind    = op[7] ? xdec_pkg::KIND_MOV : xdec_pkg::alu_kind(op[5:3]);
        ctl_nxt.len     = {1'b0, m_end};
        ctl_nxt.swapped = op[1];
        ctl_nxt.rk      = m_rk;
        ctl_nxt.rbase   = m_base;
        ctl_nxt.ridx    = m_idx;
        ctl_nxt.rscale  = m_scale;
        ctl_nxt.rv_src  = m_src;
        ctl_nxt.rv_pos  = disp_pos;
        ctl_nxt.sk      = xdec_pkg::SEC_REG;
        ctl_nxt.sv_reg  = r2;
      end
      xdec_pkg::OP_ADD_EAX, xdec_pkg::OP_SUB_EAX, xdec_pkg::OP_CMP_EAX: begin
        ctl_nxt.known  = 1'b1;
        ctl_nxt.kind   = xdec_pkg::alu_kind(op[5:3]);
        ctl_nxt.len    = 4'd5;
        ctl_nxt.rk     = xdec_pkg::RM_REG;
        ctl_nxt.ridx   = xdec_pkg::REG_NONE;
        ctl_nxt.sk     = xdec_pkg::SEC_IMM;
        ctl_nxt.sv_src = xdec_pkg::VSRC_WORD;
        ctl_nxt.sv_pos = 3'd1;
      end
      [xdec_pkg::OP_REG_LO:xdec_pkg::OP_REG_HI]: begin
        ctl_nxt.known = 1'b1;
        case (op[4:3])
          xdec_pkg::REG_GRP_INC:  ctl_nxt.kind = xdec_pkg::KIND_INC;
          xdec_pkg::REG_GRP_DEC:  ctl_nxt.kind = xdec_pkg::KIND_DEC;
          xdec_pkg::REG_GRP_PUSH: ctl_nxt.kind = xdec_pkg::KIND_PUSH;
          default:                ctl_nxt.kind = xdec_pkg::KIND_POP;
        endcase
        ctl_nxt.rk    = xdec_pkg::RM_REG;
        ctl_nxt.rbase = {1'b0, op[2:0]};
        ctl_nxt.ridx  = xdec_pkg::REG_NONE;
      end
      xdec_pkg::OP_JE, xdec_pkg::OP_JNE, xdec_pkg::OP_JMP8: begin
        ctl_nxt.known  = 1'b1;
        ctl_nxt.kind   = (op == xdec_pkg::OP_JE)  ? xdec_pkg::KIND_JE :
                         (op == xdec_pkg::OP_JNE) ? xdec_pkg::KIND_JNE : xdec_pkg::KIND_JMP;
        ctl_nxt.len    = 4'd2;
        ctl_nxt.rk     = xdec_pkg::RM_IMM;
        ctl_nxt.rv_src = xdec_pkg::VSRC_BYTE;
        ctl_nxt.rv_pos = 3'd1;
      end
      xdec_pkg::OP_CALL, xdec_pkg::OP_JMP32: begin
        ctl_nxt.known  = 1'b1;
        ctl_nxt.kind   = (op == xdec_pkg::OP_CALL) ? xdec_pkg::KIND_CALL : xdec_pkg::KIND_JMP;
        ctl_nxt.len    = 4'd5;
        ctl_nxt.rk     = xdec_pkg::RM_IMM;
        ctl_nxt.rv_src = xdec_pkg::VSRC_WORD;
        ctl_nxt.rv_pos = 3'd1;
      end
      xdec_pkg::OP_GRP_IMM32, xdec_pkg::OP_GRP_IMM8, xdec_pkg::OP_MOV_IMM: begin
        // mov r/m,imm32 is only defined with a zero reg field
        ctl_nxt.known  = (op != xdec_pkg::OP_MOV_IMM) || (r2 == 3'd0);
        ctl_nxt.kind   = (op == xdec_pkg::OP_MOV_IMM) ? xdec_pkg::KIND_MOV
                                                      : xdec_pkg::group_kind(r2);
        ctl_nxt.rk     = m_rk;
        ctl_nxt.rbase  = m_base;
        ctl_nxt.ridx   = m_idx;
        ctl_nxt.rscale = m_scale;
        ctl_nxt.rv_src = m_src;
        ctl_nxt.rv_pos = disp_pos;
        ctl_nxt.sk     = xdec_pkg::SEC_IMM;
        ctl_nxt.sv_pos = m_end;
        if (op == xdec_pkg::OP_GRP_IMM8) begin
          ctl_nxt.sv_src = xdec_pkg::VSRC_BYTE;
          ctl_nxt.len    = {1'b0, m_end} + 4'd1;
        end else begin
          ctl_nxt.sv_src = xdec_pkg::VSRC_WORD;
          ctl_nxt.len    = {1'b0, m_end} + 4'd4;
        end
      end
      xdec_pkg::OP_PUSHA: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_PUSHA;
      end
      xdec_pkg::OP_POPA: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_POPA;
      end
      xdec_pkg::OP_NOP: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_NOP;
      end
      xdec_pkg::OP_PUSHF: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_PUSHF;
      end
      xdec_pkg::OP_POPF: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_POPF;
      end
      xdec_pkg::OP_RET: begin
        ctl_nxt.known = 1'b1;
        ctl_nxt.kind  = xdec_pkg::KIND_RET;
      end
      default: ctl_nxt.known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_win_r <= in_data[xdec_pkg::WIN_W-1:0];
      s1_ctl_r <= ctl_nxt;
    end
  end

endmodule

// File: rtl/core/xdec_ext.sv
`timescale 1ns / 1ps

// Stage 2: pull displacement and immediate out of the window, check the length.
module xdec_ext (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       s1_v,
  input  logic [xdec_pkg::WIN_W-1:0] s1_win,
  input  xdec_pkg::s1_ctl_t          s1_ctl,
  output logic                       s2_v_r,
  output logic                       s2_ok_r,
  output xdec_pkg::dec_res_t         s2_res_r
);

  function automatic logic [31:0] pick(input logic [xdec_pkg::WIN_W-1:0] win,
                                       input logic [2:0] pos,
                                       input xdec_pkg::val_src_t src);
    logic [xdec_pkg::WIN_W-1:0] sh;
    logic [31:0]                v;
    sh = win >> {pos, 3'b000};
    case (src)
      xdec_pkg::VSRC_BYTE: v = {{24{sh[7]}}, sh[7:0]};
      xdec_pkg::VSRC_WORD: v = sh[31:0];
      default:             v = 32'd0;
    endcase
    return v;
  endfunction

  logic               ok_nxt;
  xdec_pkg::dec_res_t res_nxt;

  // Any truncation leaves the total length beyond the available count
  assign ok_nxt = s1_ctl.known && (s1_ctl.len <= s1_ctl.avail);

  always_comb begin
    res_nxt.kind        = s1_ctl.kind;
    res_nxt.length      = s1_ctl.len;
    res_nxt.swapped     = s1_ctl.swapped;
    res_nxt.rm_kind     = s1_ctl.rk;
    res_nxt.rm_base     = s1_ctl.rbase;
    res_nxt.rm_index    = s1_ctl.ridx;
    res_nxt.rm_scale    = s1_ctl.rscale;
    res_nxt.rm_value    = pick(s1_win, s1_ctl.rv_pos, s1_ctl.rv_src);
    res_nxt.second_kind = s1_ctl.sk;
    if (s1_ctl.sk == xdec_pkg::SEC_REG) begin
      res_nxt.second_value = {29'd0, s1_ctl.sv_reg};
    end else begin
      res_nxt.second_value = pick(s1_win, s1_ctl.sv_pos, s1_ctl.sv_src);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok_r  <= ok_nxt;
      s2_res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/core/x86_subset_instruction_decoder.sv
`timescale 1ns / 1ps

// Subset 32-bit x86 instruction decoder.
// Input word (in_*): a fetched window of 11 instruction bytes plus the count of
// valid bytes in it (counts above 11 act as 11). Output word (out_*): kind,
// length and the two operands of the instruction at byte 0; an unknown opcode
// or a window too short for the instruction gives an all-zero result.
// Exactly one output word leaves for every input word, in order.
// Pipeline: three register stages (opcode/ModRM classify, displacement and
// immediate extract plus length check, result zeroing into the output
// register). Throughput is one word per cycle while out_tready does not stall
// the output, with no feedback between the stages.
// Stall: when out_tvalid is high and out_tready low, the whole pipeline holds;
// in_tready drops in that cycle, so nothing is dropped or repeated. Bubbles
// inside the pipe do not free it while the output waits.
// Reset: synchronous, active low; all stage valid bits clear and in_tready is
// low while rst_n is low.
module x86_subset_instruction_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] window_low, [87:64] window_high, [91:88] avail_len, [95:92] zero
  input  logic [xdec_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [4:0] ins_kind, [8:5] ins_length, [9] swapped, [11:10] rm_kind,
  // [15:12] rm_base, [19:16] rm_index, [21:20] rm_scale, [53:22] rm_value,
  // [55:54] second_kind, [87:56] second_value
  output logic [xdec_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                       en;
  logic                       s1_v;
  logic [xdec_pkg::WIN_W-1:0] s1_win;
  xdec_pkg::s1_ctl_t          s1_ctl;
  logic                       s2_v;
  logic                       s2_ok;
  xdec_pkg::dec_res_t         s2_res;
  logic                       out_v_r;
  xdec_pkg::dec_res_t         out_r;
  xdec_pkg::dec_res_t         out_nxt;

  // Advance every stage together unless the output word is blocked
  assign en        = !out_v_r || out_tready;
  assign in_tready = en && rst_n;

  xdec_cls u_cls (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid && in_tready),
    .in_data  (in_tdata),
    .s1_v_r   (s1_v),
    .s1_win_r (s1_win),
    .s1_ctl_r (s1_ctl)
  );

  xdec_ext u_ext (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s1_v     (s1_v),
    .s1_win   (s1_win),
    .s1_ctl   (s1_ctl),
    .s2_v_r   (s2_v),
    .s2_ok_r  (s2_ok),
    .s2_res_r (s2_res)
  );

  // Invalid or truncated: drop every field to zero
  assign out_nxt = s2_ok ? s2_res : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_r.kind == xdec_pkg::KIND_INVALID) |->
      (out_r.length == 4'd0) && (out_r.rm_kind == xdec_pkg::RM_NONE) &&
      (out_r.second_kind == xdec_pkg::SEC_NONE))
    else $error("invalid result carries nonzero fields");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_r.kind != xdec_pkg::KIND_INVALID) |->
      (out_r.length != 4'd0) && (out_r.length <= xdec_pkg::AVAIL_MAX))
    else $error("decoded length out of range");

  a_sec_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_r.second_kind == xdec_pkg::SEC_REG) |->
      (out_r.second_value < 32'd8))
    else $error("second register number out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_v)
    else $error("accepted word missing from first stage");

endmodule

// File: tb/xdec_result_check.sv
`timescale 1ns / 1ps

module xdec_result_check
  import xdec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     words_pending
);

  // Kinds of the 81/83 immediate group, selected by the ModRM reg field
  localparam logic [8*5-1:0] GROUP_OPS = {KIND_CMP, KIND_XOR, KIND_SUB, KIND_AND,
                                          KIND_SBB, KIND_ADC, KIND_OR, KIND_ADD};

  dec_res_t expected_decodes[$];

  // ModRM, SIB and displacement starting at byte 1; pos ends past the last byte used
  function automatic bit decode_modrm(input logic [127:0] win, input int avail,
                                      inout dec_res_t r, output int pos);
    logic [7:0] modrm;
    logic [7:0] sib;
    logic       has_sib;
    pos = 1;
    sib = '0;
    if (pos + 1 > avail) return 1'b0;
    modrm = win[8*pos +: 8];
    pos++;
    r.second_kind  = SEC_REG;
    r.second_value = 32'(modrm[5:3]);
    has_sib = (modrm[7:6] != MOD_REG) && (modrm[2:0] == RM_SIB);
    if (has_sib) begin
      if (pos + 1 > avail) return 1'b0;
      sib = win[8*pos +: 8];
      pos++;
    end
    r.rm_kind  = RM_MEM;
    r.rm_index = REG_NONE;
    r.rm_scale = '0;
    r.rm_base  = {1'b0, modrm[2:0]};
    r.rm_value = '0;
    case (modrm[7:6])
      MOD_NODISP: begin
        if (modrm[2:0] == RM_DISP32) begin
          if (pos + 4 > avail) return 1'b0;
          r.rm_base  = REG_NONE;
          r.rm_value = win[8*pos +: 32];
          pos += 4;
        end
      end
      MOD_DISP8: begin
        if (pos + 1 > avail) return 1'b0;
        r.rm_value = {{24{win[8*pos+7]}}, win[8*pos +: 8]};
        pos += 1;
      end
      MOD_DISP32: begin
        if (pos + 4 > avail) return 1'b0;
        r.rm_value = win[8*pos +: 32];
        pos += 4;
      end
      default: r.rm_kind = RM_REG;
    endcase
    // SIB overrides base and index; base 5 under mod 0 stays a plain base
    if (has_sib) begin
      r.rm_base  = {1'b0, sib[2:0]};
      r.rm_index = (sib[5:3] == SIB_NO_INDEX) ? REG_NONE : {1'b0, sib[5:3]};
      r.rm_scale = sib[7:6];
    end
    return 1'b1;
  endfunction

  function automatic dec_res_t decode_window(input logic [63:0] lo, input logic [23:0] hi,
                                             input logic [3:0] cnt);
    dec_res_t     r;
    logic [127:0] win;
    logic [7:0]   op;
    int           avail;
    int           pos;
    bit           ok;
    r = '0;
    ok = 1'b0;
    pos = 0;
    win = {40'h0, hi, lo};
    avail = (cnt > AVAIL_MAX) ? WIN_BYTES : int'(cnt);
    op = win[7:0];
    if (avail != 0) begin
      r.length = 4'd1;
      if ((op >= OP_ADD_RM_LO && op <= OP_ADD_RM_HI) ||
          (op >= OP_SUB_RM_LO && op <= OP_SUB_RM_HI) ||
          (op >= OP_CMP_RM_LO && op <= OP_CMP_RM_HI) ||
          (op >= OP_MOV_RM_LO && op <= OP_MOV_RM_HI)) begin
        if (op <= OP_ADD_RM_HI) r.kind = KIND_ADD;
        else if (op <= OP_SUB_RM_HI) r.kind = KIND_SUB;
        else if (op <= OP_CMP_RM_HI) r.kind = KIND_CMP;
        else r.kind = KIND_MOV;
        ok = decode_modrm(win, avail, r, pos);
        r.length  = 4'(pos);
        r.swapped = op[1];
      end else if (op == OP_ADD_EAX || op == OP_SUB_EAX || op == OP_CMP_EAX) begin
        ok = (avail >= 5);
        r.kind = (op == OP_ADD_EAX) ? KIND_ADD : ((op == OP_SUB_EAX) ? KIND_SUB : KIND_CMP);
        r.length       = 4'd5;
        r.rm_kind      = RM_REG;
        r.rm_base      = '0;
        r.rm_index     = REG_NONE;
        r.second_kind  = SEC_IMM;
        r.second_value = win[39:8];
      end else if (op >= OP_REG_LO && op <= OP_REG_HI) begin
        ok = 1'b1;
        case (op[4:3])
          REG_GRP_INC:  r.kind = KIND_INC;
          REG_GRP_DEC:  r.kind = KIND_DEC;
          REG_GRP_PUSH: r.kind = KIND_PUSH;
          default:      r.kind = KIND_POP;
        endcase
        r.rm_kind  = RM_REG;
        r.rm_base  = {1'b0, op[2:0]};
        r.rm_index = REG_NONE;
      end else if (op == OP_JE || op == OP_JNE || op == OP_JMP8) begin
        ok = (avail >= 2);
        r.kind = (op == OP_JE) ? KIND_JE : ((op == OP_JNE) ? KIND_JNE : KIND_JMP);
        r.length   = 4'd2;
        r.rm_kind  = RM_IMM;
        r.rm_value = {{24{win[15]}}, win[15:8]};
      end else if (op == OP_CALL || op == OP_JMP32) begin
        ok = (avail >= 5);
        r.kind     = (op == OP_CALL) ? KIND_CALL : KIND_JMP;
        r.length   = 4'd5;
        r.rm_kind  = RM_IMM;
        r.rm_value = win[39:8];
      end else if (op == OP_GRP_IMM32 || op == OP_GRP_IMM8 || op == OP_MOV_IMM) begin
        ok = decode_modrm(win, avail, r, pos);
        if (op == OP_MOV_IMM) begin
          if (r.second_value != 0) ok = 1'b0;
          r.kind = KIND_MOV;
        end else begin
          r.kind = ins_kind_t'(GROUP_OPS[5*r.second_value[2:0] +: 5]);
        end
        // immediate follows the ModRM operand
        if (op == OP_GRP_IMM8) begin
          if (pos + 1 > avail) ok = 1'b0;
          r.second_value = {{24{win[8*pos+7]}}, win[8*pos +: 8]};
          pos += 1;
        end else begin
          if (pos + 4 > avail) ok = 1'b0;
          r.second_value = win[8*pos +: 32];
          pos += 4;
        end
        r.second_kind = SEC_IMM;
        r.length      = 4'(pos);
      end else begin
        ok = 1'b1;
        case (op)
          OP_PUSHA: r.kind = KIND_PUSHA;
          OP_POPA:  r.kind = KIND_POPA;
          OP_NOP:   r.kind = KIND_NOP;
          OP_PUSHF: r.kind = KIND_PUSHF;
          OP_POPF:  r.kind = KIND_POPF;
          OP_RET:   r.kind = KIND_RET;
          default:  ok = 1'b0;
        endcase
      end
    end
    if (!ok) r = '0;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dec_res_t got;
    dec_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_decodes.push_back(decode_window(in_tdata[63:0], in_tdata[87:64],
                                                 in_tdata[91:88]));
      if (out_tvalid && out_tready) begin
        got = dec_res_t'(out_tdata);
        if (expected_decodes.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual 0x%0h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_decodes.pop_front();
          compare_field("ins_kind", 32'(want.kind), 32'(got.kind));
          compare_field("ins_length", 32'(want.length), 32'(got.length));
          compare_field("swapped", 32'(want.swapped), 32'(got.swapped));
          compare_field("rm_kind", 32'(want.rm_kind), 32'(got.rm_kind));
          compare_field("rm_base", 32'(want.rm_base), 32'(got.rm_base));
          compare_field("rm_index", 32'(want.rm_index), 32'(got.rm_index));
          compare_field("rm_scale", 32'(want.rm_scale), 32'(got.rm_scale));
          compare_field("rm_value", want.rm_value, got.rm_value);
          compare_field("second_kind", 32'(want.second_kind), 32'(got.second_kind));
          compare_field("second_value", want.second_value, got.second_value);
        end
      end
      words_pending = expected_decodes.size();
    end
  end

endmodule

// File: tb/x86_subset_instruction_decoder_test.sv
`timescale 1ns / 1ps

module x86_subset_instruction_decoder_test;
  import xdec_pkg::*;

  localparam int PHASE_WORDS = 132;     // random words per idling phase
  localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest legal run
  localparam int DRAIN_CYCLES = 8;      // pipeline is 3 deep; leave margin

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [63:0] window_low, [87:64] window_high, [91:88] avail_len, [95:92] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [4:0] ins_kind, [8:5] ins_length, [9] swapped, [11:10] rm_kind,
  // [15:12] rm_base, [19:16] rm_index, [21:20] rm_scale, [53:22] rm_value,
  // [55:54] second_kind, [87:56] second_value
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int words_pending;
  int idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;  // chance per cycle that the receiver stalls
  int cycles = 0;

  x86_subset_instruction_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Watches both channels, predicts each decode and compares in order
  xdec_result_check checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("x86_subset_instruction_decoder regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one window (byte 0 in the low bits) and hold it until accepted.
  // Idle cycles go in front of the word so gaps land on every pipeline phase.
  task automatic send_word(input logic [87:0] win, input logic [3:0] cnt);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, cnt, win};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [95:0] rnd;
    logic [87:0] win;
    logic [3:0]  cnt;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: one-byte opcodes, including the empty and oversized counts
    send_word({80'h0, OP_NOP}, 4'd0);
    send_word({80'h0, OP_NOP}, 4'd15);
    send_word({80'h0, OP_PUSHA}, 4'd1);
    send_word({80'h0, OP_POPA}, 4'd1);
    send_word({80'h0, OP_PUSHF}, 4'd1);
    send_word({80'h0, OP_POPF}, 4'd1);
    send_word({80'h0, OP_RET}, 4'd1);
    // unknown opcodes: 0F and an all-ones window
    send_word({80'h0, 8'h0F}, AVAIL_MAX);
    send_word({88{1'b1}}, 4'd15);
    // eax immediates, the second one a byte short
    send_word({48'h0, 32'h8000_0000, OP_ADD_EAX}, 4'd5);
    send_word({48'h0, 32'h7FFF_FFFF, OP_SUB_EAX}, 4'd4);
    send_word({48'h0, 32'hFFFF_FFFF, OP_CMP_EAX}, AVAIL_MAX);
    // register forms: inc eax and pop edi
    send_word({80'h0, OP_REG_LO}, 4'd1);
    send_word({80'h0, OP_REG_HI}, 4'd1);
    // short branches, jne cut off before its offset
    send_word({72'h0, 8'h80, OP_JE}, 4'd2);
    send_word({72'h0, 8'h7F, OP_JNE}, 4'd1);
    send_word({72'h0, 8'h7F, OP_JMP8}, 4'd2);
    send_word({48'h0, 32'hDEAD_BEEF, OP_CALL}, 4'd5);
    send_word({48'h0, 32'h0000_0100, OP_JMP32}, 4'd5);
    // ModRM: register form, disp32 without base, SIB base 5 under mod 0,
    // SIB with scale 3 and disp32, disp8 negative with direction bit set
    send_word({72'h0, 8'hC8, OP_ADD_RM_LO + 8'h01}, 4'd2);
    send_word({40'h0, 32'h1234_5678, 8'h05, OP_ADD_RM_HI}, 4'd6);
    send_word({64'h0, 8'h25, 8'h04, OP_SUB_RM_HI}, 4'd3);
    send_word({32'h0, 32'hFFFF_FF80, 8'hCD, 8'h84, OP_CMP_RM_LO + 8'h01}, 4'd7);
    send_word({64'h0, 8'hF0, 8'h45, OP_MOV_RM_HI}, 4'd3);
    // immediate groups: full 11-byte form, then one byte short
    send_word({32'hCAFE_F00D, 32'h0000_1000, 8'h24, 8'hBC, OP_GRP_IMM32}, AVAIL_MAX);
    send_word({32'hCAFE_F00D, 32'h0000_1000, 8'h24, 8'hBC, OP_GRP_IMM32}, 4'd10);
    send_word({64'h0, 8'hFF, 8'hC9, OP_GRP_IMM8}, 4'd3);
    // mov imm32 with reg 0, then with reg 3 which is rejected
    send_word({48'h0, 32'h55AA_55AA, 8'h00, OP_MOV_IMM}, 4'd6);
    send_word({48'h0, 32'h55AA_55AA, 8'h18, OP_MOV_IMM}, AVAIL_MAX);

    // Random part, one idling setting per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        rnd = {$urandom(), $urandom(), $urandom()};
        win = rnd[87:0];
        // mostly known opcodes with random operand bytes, some raw noise
        case ($urandom_range(0, 11))
          0: win[7:0] = OP_ADD_RM_LO + 8'($urandom_range(0, 3));
          1: win[7:0] = OP_SUB_RM_LO + 8'($urandom_range(0, 3));
          2: win[7:0] = OP_CMP_RM_LO + 8'($urandom_range(0, 3));
          3: win[7:0] = OP_MOV_RM_LO + 8'($urandom_range(0, 3));
          4: begin
            case ($urandom_range(0, 2))
              0: win[7:0] = OP_ADD_EAX;
              1: win[7:0] = OP_SUB_EAX;
              default: win[7:0] = OP_CMP_EAX;
            endcase
          end
          5: win[7:0] = OP_REG_LO + 8'($urandom_range(0, 31));
          6: begin
            case ($urandom_range(0, 2))
              0: win[7:0] = OP_JE;
              1: win[7:0] = OP_JNE;
              default: win[7:0] = OP_JMP8;
            endcase
          end
          7: win[7:0] = $urandom_range(0, 1) ? OP_CALL : OP_JMP32;
          8, 9: begin
            case ($urandom_range(0, 2))
              0: win[7:0] = OP_GRP_IMM32;
              1: win[7:0] = OP_GRP_IMM8;
              default: win[7:0] = OP_MOV_IMM;
            endcase
          end
          10: begin
            case ($urandom_range(0, 5))
              0: win[7:0] = OP_PUSHA;
              1: win[7:0] = OP_POPA;
              2: win[7:0] = OP_NOP;
              3: win[7:0] = OP_PUSHF;
              4: win[7:0] = OP_POPF;
              default: win[7:0] = OP_RET;
            endcase
          end
          default: ;
        endcase
        // steer a quarter of the ModRM bytes into the SIB forms
        if ($urandom_range(0, 3) == 0) win[10:8] = RM_SIB;
        // give mov imm32 a legal reg field half the time
        if (win[7:0] == OP_MOV_IMM && $urandom_range(0, 1)) win[13:11] = 3'd0;
        // full window most of the time, otherwise any count incl. truncation
        cnt = ($urandom_range(0, 99) < 60) ? AVAIL_MAX : 4'($urandom_range(0, 15));
        send_word(win, cnt);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    // drain: wait for every predicted word, then catch any stray output
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("x86_subset_instruction_decoder regression: pass");
    end else begin
      $display("x86_subset_instruction_decoder regression: fail");
    end
    $finish;
  end

endmodule
